// ===== src/text_console_char_writer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Text console assertion macros
// Shared concurrent assertion forms for the console checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_CORE_ASSERT_SVH

// Checked on every rising edge of clk, suspended while rst_n is low.
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define TCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console package
// Command codes, character codes, sequencer states and the result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam logic [2:0] CMD_PUT     = 3'd0;
  localparam logic [2:0] CMD_CLR_ALL = 3'd1;
  localparam logic [2:0] CMD_CLR_CHR = 3'd2;
  localparam logic [2:0] CMD_FILL    = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BLANK = 8'h00;

  localparam logic [7:0] RESET_COLOR = 8'h07;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_TAB,
    ST_SWEEP,
    ST_SCR_COPY,
    ST_SCR_FILL,
    ST_DONE
  } tcw_state_t;

  typedef struct packed {
    logic [6:0]  cursor_x;
    logic [4:0]  cursor_y;
    logic [10:0] cursor_linear;
    logic [7:0]  read_char;
    logic [7:0]  read_color;
    logic        scrolled;
  } res_t;

endpackage

`default_nettype wire

// ===== src/tcw_cell_mem.sv =====
// ----------------------------------------------------------------------------
// Text console cell memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cell_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11,
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// Text console sequencer
// Cursor state, command decode and the address walks over the cell memories.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4,
  parameter int AW       = 11
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [2:0]    in_command,
  input  wire logic [7:0]    in_char_code,
  input  wire logic [7:0]    in_color,
  input  wire logic [6:0]    in_cell_x,
  input  wire logic [4:0]    in_cell_y,
  input  wire logic [7:0]    default_color,
  output logic               res_valid,
  input  wire logic          res_ready,
  output tcw_pkg::res_t      res,
  output logic               ram_we_char,
  output logic               ram_we_color,
  output logic      [AW-1:0] ram_waddr,
  output logic      [7:0]    ram_wchar,
  output logic      [7:0]    ram_wcolor,
  output logic      [AW-1:0] ram_raddr,
  input  wire logic [7:0]    ram_rchar,
  input  wire logic [7:0]    ram_rcolor
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int TW    = $clog2(TAB_STOP + 1);

  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_START = AW'(COLUMNS);
  localparam logic [AW-1:0] FILL_START = AW'((ROWS - 1) * COLUMNS);
  localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
  localparam logic [TW-1:0] LAST_TMOD  = TW'(TAB_STOP - 1);

  tcw_pkg::tcw_state_t state_r, state_nxt;

  logic [2:0]    cmd_r, cmd_nxt;
  logic [7:0]    char_r, char_nxt;
  logic [7:0]    fill_color_r, fill_color_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [TW-1:0] tmod_r, tmod_nxt;
  logic [TW-1:0] tab_left_r, tab_left_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic          scrolled_r, scrolled_nxt;
  logic [7:0]    rd_char_r, rd_char_nxt;
  logic [7:0]    rd_color_r, rd_color_nxt;

  logic          acc;
  logic          sweep_last;
  logic          col_last;
  logic          row_last;
  logic          step_scroll;
  logic [CW-1:0] step_col;
  logic [RW-1:0] step_row;
  logic [TW-1:0] step_tmod;
  logic [7:0]    step_char;
  logic [31:0]   col_ext;
  logic [31:0]   row_ext;
  logic [31:0]   lin_ext;
  logic [AW-1:0] cur_lin;
  logic [31:0]   in_lin_ext;

  assign in_stall = !((state_r == tcw_pkg::ST_IDLE) ||
                      ((state_r == tcw_pkg::ST_DONE) && res_ready));
  assign acc      = in_valid && !in_stall;

  assign sweep_last = (sweep_r == LAST_CELL);
  assign col_last   = (col_r == LAST_COL);
  assign row_last   = (row_r == LAST_ROW);

  // Cursor after one plain character; wrapping on the last row scrolls instead
  assign step_scroll = col_last && row_last;
  assign step_col    = col_last ? '0 : col_r + CW'(1);
  assign step_row    = (col_last && !row_last) ? row_r + RW'(1) : row_r;
  assign step_tmod   = (col_last || (tmod_r == LAST_TMOD)) ? '0 : tmod_r + TW'(1);
  assign step_char   = (state_r == tcw_pkg::ST_TAB) ? tcw_pkg::CH_SPACE : char_r;

  assign col_ext = 32'(col_r);
  assign row_ext = 32'(row_r);
  assign lin_ext = row_ext * COLUMNS + col_ext;
  assign cur_lin = lin_ext[AW-1:0];

  assign in_lin_ext = 32'(in_cell_y) * COLUMNS + 32'(in_cell_x);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcw_pkg::ST_INIT: begin
        if (sweep_last) state_nxt = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (acc) state_nxt = tcw_pkg::ST_EXEC;
      end
      tcw_pkg::ST_EXEC: begin
        unique case (cmd_r)
          tcw_pkg::CMD_PUT: begin
            case (char_r)
              tcw_pkg::CH_LF:  state_nxt = row_last ? tcw_pkg::ST_SCR_COPY : tcw_pkg::ST_DONE;
              tcw_pkg::CH_CR:  state_nxt = tcw_pkg::ST_DONE;
              tcw_pkg::CH_TAB: state_nxt = tcw_pkg::ST_TAB;
              default:         state_nxt = step_scroll ? tcw_pkg::ST_SCR_COPY
                                                       : tcw_pkg::ST_DONE;
            endcase
          end
          tcw_pkg::CMD_CLR_ALL,
          tcw_pkg::CMD_CLR_CHR,
          tcw_pkg::CMD_FILL: state_nxt = tcw_pkg::ST_SWEEP;
          tcw_pkg::CMD_READ: state_nxt = tcw_pkg::ST_RDWAIT;
          default:           state_nxt = tcw_pkg::ST_DONE;
        endcase
      end
      tcw_pkg::ST_TAB: begin
        if (step_scroll) state_nxt = tcw_pkg::ST_SCR_COPY;
        else if (tab_left_r == TW'(1)) state_nxt = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_SWEEP: begin
        if (sweep_last) state_nxt = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_SCR_COPY: begin
        if (sweep_last) state_nxt = tcw_pkg::ST_SCR_FILL;
      end
      tcw_pkg::ST_SCR_FILL: begin
        if (!pend_r && sweep_last) begin
          state_nxt = (tab_left_r != '0) ? tcw_pkg::ST_TAB : tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_RDWAIT: state_nxt = tcw_pkg::ST_DONE;
      tcw_pkg::ST_DONE: begin
        if (res_ready) state_nxt = acc ? tcw_pkg::ST_EXEC : tcw_pkg::ST_IDLE;
      end
      default: state_nxt = tcw_pkg::ST_INIT;
    endcase
  end

  // Datapath and memory ports
  always_comb begin
    cmd_nxt        = cmd_r;
    char_nxt       = char_r;
    fill_color_nxt = fill_color_r;
    rd_addr_nxt    = rd_addr_r;
    rd_ok_nxt      = rd_ok_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    tmod_nxt       = tmod_r;
    tab_left_nxt   = tab_left_r;
    sweep_nxt      = sweep_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    scrolled_nxt   = scrolled_r;
    rd_char_nxt    = rd_char_r;
    rd_color_nxt   = rd_color_r;

    ram_we_char  = 1'b0;
    ram_we_color = 1'b0;
    ram_waddr    = cur_lin;
    ram_wchar    = tcw_pkg::CH_BLANK;
    ram_wcolor   = default_color;
    ram_raddr    = sweep_r;

    if (acc) begin
      cmd_nxt        = in_command;
      char_nxt       = in_char_code;
      fill_color_nxt = in_color;
      rd_addr_nxt    = in_lin_ext[AW-1:0];
      rd_ok_nxt      = (32'(in_cell_x) < COLUMNS) && (32'(in_cell_y) < ROWS);
      scrolled_nxt   = 1'b0;
      tab_left_nxt   = '0;
      rd_char_nxt    = '0;
      rd_color_nxt   = '0;
    end

    // Write back the row copy read in the previous cycle
    if (pend_r) begin
      ram_we_char  = 1'b1;
      ram_we_color = 1'b1;
      ram_waddr    = pend_addr_r;
      ram_wchar    = ram_rchar;
      ram_wcolor   = ram_rcolor;
    end

    unique case (state_r)
      tcw_pkg::ST_INIT: begin
        ram_we_char  = 1'b1;
        ram_we_color = 1'b1;
        ram_waddr    = sweep_r;
        ram_wcolor   = tcw_pkg::RESET_COLOR;
        sweep_nxt    = sweep_last ? '0 : sweep_r + AW'(1);
      end
      tcw_pkg::ST_EXEC: begin
        unique case (cmd_r)
          tcw_pkg::CMD_PUT: begin
            case (char_r)
              tcw_pkg::CH_LF: begin
                col_nxt  = '0;
                tmod_nxt = '0;
                if (row_last) begin
                  sweep_nxt    = COPY_START;
                  scrolled_nxt = 1'b1;
                end else begin
                  row_nxt = row_r + RW'(1);
                end
              end
              tcw_pkg::CH_CR: begin
                col_nxt  = '0;
                tmod_nxt = '0;
              end
              tcw_pkg::CH_TAB: begin
                tab_left_nxt = TW'(TAB_STOP) - tmod_r;
              end
              default: begin
                ram_we_char = 1'b1;
                ram_waddr   = cur_lin;
                ram_wchar   = step_char;
                col_nxt     = step_col;
                row_nxt     = step_row;
                tmod_nxt    = step_tmod;
                if (step_scroll) begin
                  sweep_nxt    = COPY_START;
                  scrolled_nxt = 1'b1;
                end
              end
            endcase
          end
          tcw_pkg::CMD_CLR_ALL,
          tcw_pkg::CMD_CLR_CHR: begin
            sweep_nxt = '0;
            col_nxt   = '0;
            row_nxt   = '0;
            tmod_nxt  = '0;
          end
          tcw_pkg::CMD_FILL: begin
            sweep_nxt = '0;
          end
          tcw_pkg::CMD_READ: begin
            ram_raddr = rd_addr_r;
          end
          default: begin
          end
        endcase
      end
      tcw_pkg::ST_TAB: begin
        ram_we_char  = 1'b1;
        ram_waddr    = cur_lin;
        ram_wchar    = step_char;
        col_nxt      = step_col;
        row_nxt      = step_row;
        tmod_nxt     = step_tmod;
        tab_left_nxt = tab_left_r - TW'(1);
        if (step_scroll) begin
          sweep_nxt    = COPY_START;
          scrolled_nxt = 1'b1;
        end
      end
      tcw_pkg::ST_SWEEP: begin
        ram_we_char  = (cmd_r == tcw_pkg::CMD_CLR_ALL) || (cmd_r == tcw_pkg::CMD_CLR_CHR);
        ram_we_color = (cmd_r == tcw_pkg::CMD_CLR_ALL) || (cmd_r == tcw_pkg::CMD_FILL);
        ram_waddr    = sweep_r;
        ram_wcolor   = (cmd_r == tcw_pkg::CMD_FILL) ? fill_color_r : default_color;
        sweep_nxt    = sweep_r + AW'(1);
      end
      tcw_pkg::ST_SCR_COPY: begin
        ram_raddr     = sweep_r;
        pend_nxt      = 1'b1;
        pend_addr_nxt = sweep_r - COPY_START;
        sweep_nxt     = sweep_last ? FILL_START : sweep_r + AW'(1);
      end
      tcw_pkg::ST_SCR_FILL: begin
        // Hold the fill while the last copied cell is written back
        if (!pend_r) begin
          ram_we_char  = 1'b1;
          ram_we_color = 1'b1;
          ram_waddr    = sweep_r;
          sweep_nxt    = sweep_r + AW'(1);
        end
      end
      tcw_pkg::ST_RDWAIT: begin
        rd_char_nxt  = rd_ok_r ? ram_rchar : '0;
        rd_color_nxt = rd_ok_r ? ram_rcolor : '0;
      end
      tcw_pkg::ST_IDLE, tcw_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_valid         = (state_r == tcw_pkg::ST_DONE);
    res.cursor_x      = col_ext[6:0];
    res.cursor_y      = row_ext[4:0];
    res.cursor_linear = lin_ext[10:0];
    res.read_char     = rd_char_r;
    res.read_color    = rd_color_r;
    res.scrolled      = scrolled_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= tcw_pkg::ST_INIT;
      col_r      <= '0;
      row_r      <= '0;
      tmod_r     <= '0;
      tab_left_r <= '0;
      sweep_r    <= '0;
      pend_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      tmod_r     <= tmod_nxt;
      tab_left_r <= tab_left_nxt;
      sweep_r    <= sweep_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    char_r       <= char_nxt;
    fill_color_r <= fill_color_nxt;
    rd_addr_r    <= rd_addr_nxt;
    rd_ok_r      <= rd_ok_nxt;
    pend_addr_r  <= pend_addr_nxt;
    scrolled_r   <= scrolled_nxt;
    rd_char_r    <= rd_char_nxt;
    rd_color_r   <= rd_color_nxt;
  end

endmodule

`default_nettype wire

// ===== src/text_console_char_writer_core.sv =====
// ----------------------------------------------------------------------------
// Text console character writer
// Character/color cell screen with cursor, wrap, scroll, clears and reads.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  in_     | input     | in_valid/in_stall  | command, char_code, color, cell_x/y
//  out_    | output    | out_valid/out_stall| cursor_x/y/linear, read_*, scrolled
//  cfg_    | input     | cfg_valid/cfg_ready| default_color
//
//  Plain character, newline, return, fill-free commands: execute, then result.
//  Read: one registered memory read before the result. Tab: writes the spaces up to the next tab stop.
//  Clear/fill: a sweep over every cell, one cell per cycle on the write port.
//  Each scroll adds a row copy, then a blank row fill.
//  After reset the input stalls during a clearing pass over every cell.
//  A result waits in the output register while the next input is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer_core #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_command,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [7:0]  in_color,
  input  wire logic [6:0]  in_cell_x,
  input  wire logic [4:0]  in_cell_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [6:0]  out_cursor_x,
  output logic      [4:0]  out_cursor_y,
  output logic      [10:0] out_cursor_linear,
  output logic      [7:0]  out_read_char,
  output logic      [7:0]  out_read_color,
  output logic             out_scrolled,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_default_color
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic [7:0]    default_color_r, default_color_nxt;
  logic          out_valid_r, out_valid_nxt;
  tcw_pkg::res_t out_res_r, out_res_nxt;

  logic          res_valid;
  logic          res_ready;
  tcw_pkg::res_t res;

  logic          ram_we_char;
  logic          ram_we_color;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wchar;
  logic [7:0]    ram_wcolor;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rchar;
  logic [7:0]    ram_rcolor;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    default_color_nxt = default_color_r;
    if (cfg_valid && cfg_ready) default_color_nxt = cfg_default_color;

    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) out_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_color_r <= tcw_pkg::RESET_COLOR;
      out_valid_r     <= 1'b0;
    end else begin
      default_color_r <= default_color_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_x      = out_res_r.cursor_x;
  assign out_cursor_y      = out_res_r.cursor_y;
  assign out_cursor_linear = out_res_r.cursor_linear;
  assign out_read_char     = out_res_r.read_char;
  assign out_read_color    = out_res_r.read_color;
  assign out_scrolled      = out_res_r.scrolled;

  tcw_ctrl #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP),
    .AW       (AW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_char_code  (in_char_code),
    .in_color      (in_color),
    .in_cell_x     (in_cell_x),
    .in_cell_y     (in_cell_y),
    .default_color (default_color_r),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .ram_we_char   (ram_we_char),
    .ram_we_color  (ram_we_color),
    .ram_waddr     (ram_waddr),
    .ram_wchar     (ram_wchar),
    .ram_wcolor    (ram_wcolor),
    .ram_raddr     (ram_raddr),
    .ram_rchar     (ram_rchar),
    .ram_rcolor    (ram_rcolor)
  );

  tcw_cell_mem #(
    .DEPTH (CELLS),
    .AW    (AW),
    .DW    (8)
  ) u_char_mem (
    .clk   (clk),
    .we    (ram_we_char),
    .waddr (ram_waddr),
    .wdata (ram_wchar),
    .raddr (ram_raddr),
    .rdata (ram_rchar)
  );

  tcw_cell_mem #(
    .DEPTH (CELLS),
    .AW    (AW),
    .DW    (8)
  ) u_color_mem (
    .clk   (clk),
    .we    (ram_we_color),
    .waddr (ram_waddr),
    .wdata (ram_wcolor),
    .raddr (ram_raddr),
    .rdata (ram_rcolor)
  );

endmodule

`default_nettype wire

// ===== src/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// Text console port checker
// Port-level properties of the console, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_char_writer_core_assert.svh"

module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [2:0]  in_command,
  input wire logic [7:0]  in_char_code,
  input wire logic [7:0]  in_color,
  input wire logic [6:0]  in_cell_x,
  input wire logic [4:0]  in_cell_y,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [6:0]  out_cursor_x,
  input wire logic [4:0]  out_cursor_y,
  input wire logic [10:0] out_cursor_linear,
  input wire logic [7:0]  out_read_char,
  input wire logic [7:0]  out_read_color,
  input wire logic        out_scrolled,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [7:0]  cfg_default_color
);

  // Linear position is only comparable while the cursor fields are not masked
  localparam bit LIN_OK = (COLUMNS <= 128) && (ROWS <= 32) && (COLUMNS * ROWS <= 2048);
  localparam bit ROW_OK = (ROWS <= 32);

  `TCW_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_cursor_x) && $stable(out_cursor_y) && $stable(out_read_char) && $stable(out_scrolled), "result changed while stalled")
  `TCW_ASSERT(a_linear, out_valid |-> (!LIN_OK || (out_cursor_linear == 11'(32'(out_cursor_y) * COLUMNS + 32'(out_cursor_x)))), "cursor_linear does not match cursor")
  `TCW_ASSERT(a_scroll_row, out_valid && out_scrolled |-> (!ROW_OK || (out_cursor_y == 5'(ROWS - 1))), "scroll left cursor off the last row")
  `TCW_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> in_stall && !out_valid, "input taken or result shown right after reset")

endmodule

bind text_console_char_writer_core tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (.*);

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Sends put, clear, fill, read and spare commands over the stall handshake.
// A behavioral screen model predicts every cursor and read result, and each
// result is checked field by field, in order, under several blank colors.
// ----------------------------------------------------------------------------
module testbench;
  import tcw_pkg::*;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 4;
  localparam int CELLS    = COLUMNS * ROWS;

  localparam int MAX_REPORTS = 10;
  localparam int TAIL_CYCLES = 2 * CELLS + 100;
  localparam longint unsigned LIMIT_CYCLES = 64'd6_000_000;

  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
  localparam logic [7:0] CH_TILDE        = 8'h7E;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] char_code;
    logic [7:0] color;
    logic [6:0] cell_x;
    logic [4:0] cell_y;
  } console_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_command = CMD_PUT;
  logic [7:0]  in_char_code = CH_BLANK;
  logic [7:0]  in_color = 8'h00;
  logic [6:0]  in_cell_x = 7'd0;
  logic [4:0]  in_cell_y = 5'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  out_cursor_x;
  logic [4:0]  out_cursor_y;
  logic [10:0] out_cursor_linear;
  logic [7:0]  out_read_char;
  logic [7:0]  out_read_color;
  logic        out_scrolled;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_default_color = RESET_COLOR;

  // screen model: color in bits 15..8, character in bits 7..0
  logic [15:0] screen_model [CELLS];
  int unsigned cursor_col;
  int unsigned cursor_row;
  logic [7:0]  blank_color;

  res_t        pending_results [$];
  bit          calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned scroll_count = 0;
  int unsigned read_count = 0;
  int unsigned color_writes = 0;
  longint unsigned cycle_count = 0;

  text_console_char_writer_core #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_char_code      (in_char_code),
    .in_color          (in_color),
    .in_cell_x         (in_cell_x),
    .in_cell_y         (in_cell_y),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cursor_x      (out_cursor_x),
    .out_cursor_y      (out_cursor_y),
    .out_cursor_linear (out_cursor_linear),
    .out_read_char     (out_read_char),
    .out_read_color    (out_read_color),
    .out_scrolled      (out_scrolled),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_default_color (cfg_default_color)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("testbench: timeout, %0d results still pending", pending_results.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic void screen_reset();
    for (int i = 0; i < CELLS; i++) screen_model[i] = {RESET_COLOR, CH_BLANK};
    cursor_col  = 0;
    cursor_row  = 0;
    blank_color = RESET_COLOR;
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = {blank_color, CH_BLANK};
    if (cursor_row > 0) cursor_row--;
  endfunction

  function automatic bit settle_cursor();
    bit did;
    did = 1'b0;
    if (cursor_col >= COLUMNS) begin
      cursor_col = 0;
      cursor_row++;
    end
    if (cursor_row >= ROWS) begin
      scroll_screen();
      did = 1'b1;
    end
    return did;
  endfunction

  // keep the cell color, replace the character
  function automatic bit write_plain(logic [7:0] ch);
    int unsigned idx;
    idx = cursor_row * COLUMNS + cursor_col;
    if (idx < CELLS) screen_model[idx][7:0] = ch;
    cursor_col++;
    return settle_cursor();
  endfunction

  function automatic bit write_char(logic [7:0] ch);
    bit          did;
    int unsigned spaces;
    did = 1'b0;
    case (ch)
      CH_LF: begin
        cursor_col = 0;
        cursor_row++;
        did = settle_cursor();
      end
      CH_CR: cursor_col = 0;
      CH_TAB: begin
        // count is fixed before the first space moves the cursor
        spaces = TAB_STOP - (cursor_col % TAB_STOP);
        for (int i = 0; i < spaces; i++) if (write_plain(CH_SPACE)) did = 1'b1;
      end
      default: did = write_plain(ch);
    endcase
    return did;
  endfunction

  function automatic res_t predict_result(console_cmd_t c);
    res_t        r;
    int unsigned idx;
    r = '0;
    case (c.command)
      CMD_PUT: r.scrolled = write_char(c.char_code);
      CMD_CLR_ALL: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = {blank_color, CH_BLANK};
        cursor_col = 0;
        cursor_row = 0;
      end
      CMD_CLR_CHR: begin
        for (int i = 0; i < CELLS; i++) screen_model[i][7:0] = CH_BLANK;
        cursor_col = 0;
        cursor_row = 0;
      end
      CMD_FILL: for (int i = 0; i < CELLS; i++) screen_model[i][15:8] = c.color;
      CMD_READ: begin
        read_count++;
        if (c.cell_x < COLUMNS && c.cell_y < ROWS) begin
          idx = c.cell_y * COLUMNS + c.cell_x;
          r.read_char  = screen_model[idx][7:0];
          r.read_color = screen_model[idx][15:8];
        end
      end
      default: ;
    endcase
    if (r.scrolled) scroll_count++;
    r.cursor_x      = cursor_col[6:0];
    r.cursor_y      = cursor_row[4:0];
    r.cursor_linear = 11'(cursor_row * COLUMNS + cursor_col);
    return r;
  endfunction

  // ------------------------------------------------------------- checking

  task automatic compare_field(input string field, input logic [10:0] want,
                               input logic [10:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("testbench: result %0d %s expected %0d, got %0d",
                 results_seen, field, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t        got;
    res_t        want;
    int unsigned stall_draw;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      results_seen++;
      got = {out_cursor_x, out_cursor_y, out_cursor_linear,
             out_read_char, out_read_color, out_scrolled};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("testbench: result %0d arrived with nothing expected", results_seen);
      end else begin
        want = pending_results.pop_front();
        compare_field("cursor_x", want.cursor_x, got.cursor_x);
        compare_field("cursor_y", want.cursor_y, got.cursor_y);
        compare_field("cursor_linear", want.cursor_linear, got.cursor_linear);
        compare_field("read_char", want.read_char, got.read_char);
        compare_field("read_color", want.read_color, got.read_color);
        compare_field("scrolled", want.scrolled, got.scrolled);
      end
      stall_draw = calm ? 0 : $urandom_range(0, 9);
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  // ------------------------------------------------------------- stimulus

  // hold the payload until the transfer, then predict
  task automatic send_item(input console_cmd_t c);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= c.command;
    in_char_code <= c.char_code;
    in_color     <= c.color;
    in_cell_x    <= c.cell_x;
    in_cell_y    <= c.cell_y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_result(c));
    items_sent++;
  endtask

  // unused fields carry random bits
  function automatic console_cmd_t noise_item();
    console_cmd_t c;
    c.command   = 3'($urandom_range(0, 7));
    c.char_code = 8'($urandom_range(0, 255));
    c.color     = 8'($urandom_range(0, 255));
    c.cell_x    = 7'($urandom_range(0, 127));
    c.cell_y    = 5'($urandom_range(0, 31));
    return c;
  endfunction

  task automatic put(input logic [7:0] ch);
    console_cmd_t c;
    c = noise_item();
    c.command   = CMD_PUT;
    c.char_code = ch;
    send_item(c);
  endtask

  task automatic read_cell(input int unsigned x, input int unsigned y);
    console_cmd_t c;
    c = noise_item();
    c.command = CMD_READ;
    c.cell_x  = 7'(x);
    c.cell_y  = 5'(y);
    send_item(c);
  endtask

  task automatic screen_op(input logic [2:0] command, input logic [7:0] color);
    console_cmd_t c;
    c = noise_item();
    c.command = command;
    c.color   = color;
    send_item(c);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_default_color(input logic [7:0] value);
    wait_results_drained();
    cfg_valid         <= 1'b1;
    cfg_default_color <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    blank_color = value;
    color_writes++;
  endtask

  function automatic logic [7:0] text_byte();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 8'($urandom_range(CH_SPACE, CH_TILDE));
    if (pick < 80) return 8'($urandom_range(0, 255));
    if (pick < 88) return CH_TAB;
    if (pick < 93) return CH_CR;
    return CH_LF;
  endfunction

  // mostly the rows just written, sometimes anywhere the fields reach
  task automatic read_near_cursor();
    int unsigned pick;
    int unsigned x;
    int unsigned y;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      x = $urandom_range(0, COLUMNS - 1);
      y = (cursor_row > 0 && $urandom_range(0, 1) == 1) ? cursor_row - 1 : cursor_row;
    end else if (pick < 9) begin
      x = $urandom_range(0, COLUMNS - 1);
      y = $urandom_range(0, ROWS - 1);
    end else begin
      x = $urandom_range(0, 127);
      y = $urandom_range(0, 31);
    end
    read_cell(x, y);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_state();
    read_cell(0, 0);
    read_cell(COLUMNS - 1, ROWS - 1);
    read_cell(COLUMNS, 0);
    read_cell(0, ROWS);
    read_cell(127, 31);
  endtask

  task automatic test_control_chars();
    put(8'h41);
    put(CH_BLANK);
    put(8'hFF);
    put(CH_TAB);
    put(CH_TAB);
    put(8'h5A);
    put(CH_CR);
    put(CH_LF);
    read_cell(1, 0);
    read_cell(2, 0);
    read_cell(3, 0);
    read_cell(7, 0);
  endtask

  task automatic test_screen_commands();
    screen_op(CMD_FILL, 8'hA5);
    read_cell(2, 0);
    screen_op(CMD_CLR_CHR, 8'h00);
    read_cell(2, 0);
    put(8'h42);
    screen_op(CMD_CLR_ALL, 8'hFF);
    read_cell(0, 0);
    for (int op = CMD_SPARE_FIRST; op <= CMD_SPARE_LAST; op++) screen_op(3'(op), 8'h5A);
    read_cell(COLUMNS - 1, ROWS - 1);
  endtask

  // lines of text from the bottom row down, so newlines and wraps scroll
  task automatic test_text_stream(input int unsigned count);
    int unsigned stop_at;
    int unsigned len;
    int unsigned pick;
    stop_at = items_sent + count;
    len = $urandom_range(ROWS - 5, ROWS + 3);
    for (int i = 0; i < len; i++) put(CH_LF);
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 19) == 0) calm = !calm;
      pick = $urandom_range(0, 19);
      if (pick < 12) len = $urandom_range(0, 3);
      else if (pick < 17) len = $urandom_range(4, 20);
      else len = $urandom_range(60, 100);
      for (int k = 0; k < len && items_sent < stop_at; k++) begin
        put(text_byte());
        if ($urandom_range(0, 6) == 0) read_near_cursor();
      end
      if ($urandom_range(0, 9) != 0) put(CH_LF);
    end
    calm = 1'b0;
  endtask

  task automatic test_mixed_commands(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 29) == 0) calm = !calm;
      pick = $urandom_range(0, 99);
      if (pick < 40) put(text_byte());
      else if (pick < 55) read_near_cursor();
      else if (pick < 59) screen_op(CMD_CLR_ALL, 8'($urandom_range(0, 255)));
      else if (pick < 63) screen_op(CMD_CLR_CHR, 8'($urandom_range(0, 255)));
      else if (pick < 68) screen_op(CMD_FILL, 8'($urandom_range(0, 255)));
      else if (pick < 71)
        screen_op(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)), 8'h00);
      else if (pick < 78) put(CH_LF);
      else begin
        // long run of text, often long enough for a column wrap
        len = $urandom_range(5, 90);
        for (int k = 0; k < len && items_sent < stop_at; k++)
          put(8'($urandom_range(CH_SPACE, CH_TILDE)));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    screen_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_control_chars();
    set_default_color(8'h0E);
    test_screen_commands();
    set_default_color(8'h00);
    test_text_stream(180);
    set_default_color(8'hFF);
    test_mixed_commands(140);
    set_default_color(8'($urandom_range(1, 254)));
    test_text_stream(110);
    set_default_color(8'h0F);
    test_mixed_commands(100);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("testbench: %0d commands, %0d results, %0d scrolls, %0d cell reads",
             items_sent, results_seen, scroll_count, read_count);
    $display("testbench: %0d blank color settings, %0d mismatches",
             color_writes, mismatches);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
